// ----- rtl/lcs_pkg.sv -----
// Shared types and constants for the longest common subsequence block.
`default_nettype none
package lcs_pkg;
    localparam int LCS_MAX_LEN = 64;
    localparam int SYM_W = 8;
    localparam int VAL_W = 7;

    localparam logic [1:0] CMD_FIRST  = 2'd0;
    localparam logic [1:0] CMD_SECOND = 2'd1;
    localparam logic [1:0] CMD_RUN    = 2'd2;

    typedef enum logic [1:0] {
        DIR_UP   = 2'd0,
        DIR_LEFT = 2'd1,
        DIR_DIAG = 2'd2
    } lcs_dir_t;

    // data handed from one cell to the next
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
        logic [VAL_W-1:0] left;
        logic [VAL_W-1:0] diag;
    } lcs_link_t;
endpackage
`default_nettype wire

// ----- rtl/lcs_cell.sv -----
// One column cell of the systolic score array with its traceback column store.
`default_nettype none
module lcs_cell #(
    parameter int MAX_LEN = lcs_pkg::LCS_MAX_LEN,
    parameter int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       clear,
    input  lcs_pkg::lcs_link_t        link_in,
    output lcs_pkg::lcs_link_t        link_out,
    input  wire                       load_en,
    input  wire [lcs_pkg::SYM_W-1:0]  load_sym,
    input  wire [AW-1:0]              rd_addr,
    output lcs_pkg::lcs_dir_t         rd_dir,
    output logic [lcs_pkg::SYM_W-1:0] sym,
    output logic [lcs_pkg::VAL_W-1:0] val
);
    import lcs_pkg::*;

    logic [VAL_W-1:0] val_reg;
    logic [SYM_W-1:0] sym_reg;
    logic [AW-1:0]    row_reg;
    logic             out_valid_reg;
    logic [SYM_W-1:0] out_sym_reg;
    logic [VAL_W-1:0] out_diag_reg;
    lcs_dir_t         mem [MAX_LEN];
    lcs_dir_t         rd_reg;

    logic [VAL_W-1:0] best;
    logic [VAL_W-1:0] diag_inc;
    lcs_dir_t         dir;

    always_comb
    begin
        diag_inc = link_in.diag + VAL_W'(1);
        best = (link_in.left > val_reg) ? link_in.left : val_reg;
        if (link_in.sym == sym_reg && diag_inc > best)
        begin
            best = diag_inc;
        end
        if (best == val_reg)
        begin
            dir = DIR_UP;
        end
        else if (best == link_in.left)
        begin
            dir = DIR_LEFT;
        end
        else
        begin
            dir = DIR_DIAG;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (clear)
        begin
            val_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= link_in.valid;
            if (link_in.valid)
            begin
                val_reg <= best;
                row_reg <= row_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            sym_reg <= load_sym;
        end
        if (link_in.valid)
        begin
            out_sym_reg  <= link_in.sym;
            out_diag_reg <= val_reg;
            mem[row_reg] <= dir;
        end
        rd_reg <= mem[rd_addr];
    end

    assign link_out.valid = out_valid_reg;
    assign link_out.sym   = out_sym_reg;
    assign link_out.left  = val_reg;
    assign link_out.diag  = out_diag_reg;
    assign rd_dir = rd_reg;
    assign sym    = sym_reg;
    assign val    = val_reg;
endmodule
`default_nettype wire

// ----- rtl/longest_common_subsequence.sv -----
// Top level: string loading, systolic table fill, traceback and result output.
// Symbols are loaded one word per cycle while idle (cmd 0 first string, cmd 1 second
// string, at most MAX_LEN each, extra symbols dropped and flagged). A compute word runs the
// first string through a chain of MAX_LEN column cells, one row per cycle; the traceback
// then reads each cell's direction store in a read state and a use state per step (at most
// n + m steps), and each result word is read from the answer buffer and then written to
// the output register. Input is not taken during a compute.
`default_nettype none
module longest_common_subsequence #(
    parameter int MAX_LEN = lcs_pkg::LCS_MAX_LEN
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] symbol
    input  wire  [1:0]  s_axis_tuser,   // [1:0] cmd
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_symbol, [14:8] common_length,
                                        // [15] overflowed
    output logic        m_axis_tuser,   // [0] out_valid
    output logic        m_axis_tlast    // out_last
);
    import lcs_pkg::*;

    localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int FW = $clog2(2 * MAX_LEN + 3);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_FILL   = 6'b000010,
        ST_TB_RD  = 6'b000100,
        ST_TB_USE = 6'b001000,
        ST_EM_RD  = 6'b010000,
        ST_EM_WR  = 6'b100000
    } state_t;

    state_t           state_reg;
    logic [VAL_W-1:0] n_reg, m_reg;
    logic             ovf_reg;
    logic [FW-1:0]    fill_reg;
    logic             feed_valid_reg;
    logic [VAL_W-1:0] i_reg, j_reg, pos_reg, len_reg, k_reg;
    logic [SYM_W-1:0] first_mem [MAX_LEN];
    logic [SYM_W-1:0] first_q;
    logic [SYM_W-1:0] ans_mem [MAX_LEN];
    logic [SYM_W-1:0] ans_q;
    logic             out_valid_reg, out_user_reg, out_last_reg;
    logic [SYM_W-1:0] out_sym_reg;
    logic [VAL_W-1:0] out_len_reg;
    logic             out_ovf_reg;

    lcs_link_t        links [MAX_LEN+1];
    lcs_dir_t         cell_dir [MAX_LEN];
    logic [SYM_W-1:0] cell_sym [MAX_LEN];
    logic [VAL_W-1:0] cell_val [MAX_LEN];

    logic          accept;
    logic          start;
    logic [AW-1:0] row_addr;
    logic [AW-1:0] col;
    logic [AW-1:0] m_last;
    logic          out_free;
    logic          out_load;
    logic          emit_last;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign start    = accept && s_axis_tuser == CMD_RUN;
    assign row_addr = AW'(i_reg - VAL_W'(1));
    assign col      = AW'(j_reg - VAL_W'(1));
    assign m_last   = AW'(m_reg - VAL_W'(1));
    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (state_reg == ST_EM_WR) && out_free;
    assign emit_last = (len_reg == '0) || (k_reg + VAL_W'(1) == len_reg);

    assign links[0].valid = feed_valid_reg;
    assign links[0].sym   = first_q;
    assign links[0].left  = '0;
    assign links[0].diag  = '0;

    for (genvar c = 0; c < MAX_LEN; c++)
    begin : g_cell
        logic load_en;
        assign load_en = accept && s_axis_tuser == CMD_SECOND
                         && m_reg < VAL_W'(MAX_LEN) && AW'(m_reg) == AW'(c);
        lcs_cell #(.MAX_LEN(MAX_LEN), .AW(AW)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .clear    (start),
            .link_in  (links[c]),
            .link_out (links[c+1]),
            .load_en  (load_en),
            .load_sym (s_axis_tdata),
            .rd_addr  (row_addr),
            .rd_dir   (cell_dir[c]),
            .sym      (cell_sym[c]),
            .val      (cell_val[c])
        );
    end

    // string and answer stores
    always_ff @(posedge clk)
    begin
        if (accept && s_axis_tuser == CMD_FIRST && n_reg < VAL_W'(MAX_LEN))
        begin
            first_mem[AW'(n_reg)] <= s_axis_tdata;
        end
        first_q <= first_mem[AW'(fill_reg)];
        if (state_reg == ST_TB_USE && cell_dir[col] == DIR_DIAG && pos_reg != '0)
        begin
            ans_mem[AW'(pos_reg - VAL_W'(1))] <= cell_sym[col];
        end
        ans_q <= ans_mem[AW'(k_reg)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            n_reg          <= '0;
            m_reg          <= '0;
            ovf_reg        <= 1'b0;
            fill_reg       <= '0;
            feed_valid_reg <= 1'b0;
            i_reg          <= '0;
            j_reg          <= '0;
            pos_reg        <= '0;
            len_reg        <= '0;
            k_reg          <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_load || (out_valid_reg && !m_axis_tready);
            case (state_reg)
                ST_IDLE:
                begin
                    fill_reg <= '0;
                    if (accept)
                    begin
                        case (s_axis_tuser)
                            CMD_FIRST:
                            begin
                                if (n_reg < VAL_W'(MAX_LEN))
                                    n_reg <= n_reg + VAL_W'(1);
                                else
                                    ovf_reg <= 1'b1;
                            end
                            CMD_SECOND:
                            begin
                                if (m_reg < VAL_W'(MAX_LEN))
                                    m_reg <= m_reg + VAL_W'(1);
                                else
                                    ovf_reg <= 1'b1;
                            end
                            CMD_RUN:
                            begin
                                state_reg <= ST_FILL;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_FILL:
                begin
                    feed_valid_reg <= FW'(fill_reg) < FW'(n_reg);
                    fill_reg <= fill_reg + FW'(1);
                    // wait for the last row to clear the far end of the chain
                    if (fill_reg == FW'(n_reg) + FW'(MAX_LEN + 1))
                    begin
                        if (n_reg == '0 || m_reg == '0)
                        begin
                            len_reg <= '0;
                            pos_reg <= '0;
                        end
                        else
                        begin
                            len_reg <= cell_val[m_last];
                            pos_reg <= cell_val[m_last];
                        end
                        i_reg     <= n_reg;
                        j_reg     <= m_reg;
                        state_reg <= ST_TB_RD;
                    end
                end
                ST_TB_RD:
                begin
                    if (i_reg == '0 || j_reg == '0)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_EM_RD;
                    end
                    else
                    begin
                        state_reg <= ST_TB_USE;
                    end
                end
                ST_TB_USE:
                begin
                    case (cell_dir[col])
                        DIR_UP:
                        begin
                            i_reg <= i_reg - VAL_W'(1);
                        end
                        DIR_LEFT:
                        begin
                            j_reg <= j_reg - VAL_W'(1);
                        end
                        default:
                        begin
                            if (pos_reg != '0)
                                pos_reg <= pos_reg - VAL_W'(1);
                            i_reg <= i_reg - VAL_W'(1);
                            j_reg <= j_reg - VAL_W'(1);
                        end
                    endcase
                    state_reg <= ST_TB_RD;
                end
                ST_EM_RD:
                begin
                    state_reg <= ST_EM_WR;
                end
                ST_EM_WR:
                begin
                    if (out_free)
                    begin
                        if (emit_last)
                        begin
                            n_reg     <= '0;
                            m_reg     <= '0;
                            ovf_reg   <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            k_reg     <= k_reg + VAL_W'(1);
                            state_reg <= ST_EM_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // output word payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_sym_reg  <= (len_reg == '0) ? '0 : ans_q;
            out_user_reg <= (len_reg != '0);
            out_last_reg <= emit_last;
            out_len_reg  <= len_reg;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_ovf_reg, out_len_reg, out_sym_reg};
    assign m_axis_tuser  = out_user_reg;
    assign m_axis_tlast  = out_last_reg;
endmodule
`default_nettype wire

// ----- rtl/lcs_checker.sv -----
// Port-level assertions for the longest common subsequence block, with its bind.
`default_nettype none
module lcs_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire [7:0]  s_axis_tdata,
    input wire [1:0]  s_axis_tuser,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [15:0] m_axis_tdata,
    input wire        m_axis_tuser,
    input wire        m_axis_tlast
);
    // a stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output word changed while stalled");

    // no new input while a result is still being emitted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready in the middle of a result");

    // empty result is a single last word with zero length
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && m_axis_tdata[14:8] == 7'd0)
        else $error("bad empty result word");

    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[14:8] != 7'd0)
        else $error("symbol word with zero length");
endmodule

bind longest_common_subsequence lcs_checker u_lcs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
